// ===== rtl/core/dlgs_pkg.sv =====
// Shared constants, stage types and arithmetic step functions for the
// dual-lobe GGX specular pipeline. No dependencies.
package dlgs_pkg;

   // Fixed-point constants
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [30:0] F0_Q30  = 31'd42949673;
   localparam logic [30:0] OMF_Q30 = ONE_Q30 - F0_Q30;
   localparam logic [17:0] PI_Q16  = 18'd205887;
   localparam logic [23:0] D_MAX   = 24'h80_0000;

   // Iterative unit lengths (one step per stage)
   localparam int SQ_STEPS = 25;
   localparam int UD_STEPS = 31;
   localparam int GD_STEPS = 24;

   // Total register stages from input beat to output register
   localparam int LATENCY = 4 + SQ_STEPS + UD_STEPS + 7 + GD_STEPS + 5;

   // Register indexes
   localparam logic [2:0] CSR_ROUGH_PRI = 3'd0;
   localparam logic [2:0] CSR_ROUGH_SEC = 3'd1;
   localparam logic [2:0] CSR_RATIO     = 3'd2;
   localparam logic [2:0] CSR_STR_RED   = 3'd3;
   localparam logic [2:0] CSR_STR_GREEN = 3'd4;
   localparam logic [2:0] CSR_STR_BLUE  = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_ROUGH_PRI = 16'd19661;
   localparam logic [15:0] RST_ROUGH_SEC = 16'd39322;
   localparam logic [15:0] RST_RATIO     = 16'd32768;
   localparam logic [15:0] RST_STRENGTH  = 16'd6554;

   // Square root stage: remaining radicand, partial root, carried dots
   typedef struct packed {
      logic [50:0]        rad;
      logic [50:0]        root;
      logic signed [35:0] ns;
      logic signed [35:0] sv;
   } sq_type;

   // Unit-dot divider lane
   typedef struct packed {
      logic [25:0] rem;
      logic [30:0] quo;
      logic [6:0]  lo;
      logic        zero;
      logic        ovf;
   } ud_lane_type;

   typedef struct packed {
      logic [24:0]            len;
      ud_lane_type [1:0]      lane;
   } ud_type;

   // GGX divider lane
   typedef struct packed {
      logic [47:0] pd;
      logic [47:0] rem;
      logic [23:0] quo;
      logic        a2z;
      logic        ovf;
   } gd_lane_type;

   typedef struct packed {
      gd_lane_type [1:0] lane;
      logic [30:0]       f;
   } gd_type;

   // One digit of the integer square root, bit weight 4^k
   function automatic sq_type sq_step(sq_type s, logic [4:0] k);
      sq_type      o;
      logic [50:0] b;
      logic [50:0] rb;
      o  = s;
      b  = 51'(1) << {k, 1'b0};
      rb = s.root + b;
      if (s.rad >= rb) begin
         o.rad  = s.rad - rb;
         o.root = (s.root >> 1) + b;
      end else begin
         o.root = s.root >> 1;
      end
      return o;
   endfunction

   // Set up dot / len: clamp cases and first partial remainder
   function automatic ud_lane_type ud_init(logic signed [35:0] dot, logic [24:0] len);
      ud_lane_type o;
      o.zero = (len == 25'd0) || dot[35] || (dot == 36'sd0);
      o.ovf  = (dot[34:7] >= {3'b0, len});
      o.rem  = (o.zero || o.ovf) ? 26'd0 : dot[32:7];
      o.lo   = dot[6:0];
      o.quo  = '0;
      return o;
   endfunction

   // One restoring quotient bit for both unit-dot lanes
   function automatic ud_type ud_step(ud_type u, logic [4:0] j);
      ud_type      o;
      logic [30:0] num;
      logic [26:0] t;
      o = u;
      for (int l = 0; l < 2; l++) begin
         num = {u.lane[l].lo, 24'd0};
         t   = {u.lane[l].rem, num[j]};
         if (t >= {2'b0, u.len}) begin
            o.lane[l].rem    = 26'(t - {2'b0, u.len});
            o.lane[l].quo[j] = 1'b1;
         end else begin
            o.lane[l].rem = t[25:0];
         end
      end
      return o;
   endfunction

   function automatic logic [30:0] ud_final(ud_lane_type u);
      logic [30:0] r;
      if (u.zero)
         r = '0;
      else if (u.ovf || (u.quo > ONE_Q30))
         r = ONE_Q30;
      else
         r = u.quo;
      return r;
   endfunction

   // Set up a2 * 2^32 / pd
   function automatic gd_lane_type gd_init(logic [29:0] a2, logic [47:0] pd);
      gd_lane_type o;
      logic [47:0] num;
      num   = {10'd0, a2, 8'd0};
      o.pd  = pd;
      o.a2z = (a2 == 30'd0);
      o.ovf = (num >= pd);
      o.rem = o.ovf ? 48'd0 : num;
      o.quo = '0;
      return o;
   endfunction

   function automatic gd_type gd_step(gd_type g, logic [4:0] j);
      gd_type      o;
      logic [48:0] t;
      o = g;
      for (int l = 0; l < 2; l++) begin
         t = {g.lane[l].rem, 1'b0};
         if (t >= {1'b0, g.lane[l].pd}) begin
            o.lane[l].rem    = 48'(t - {1'b0, g.lane[l].pd});
            o.lane[l].quo[j] = 1'b1;
         end else begin
            o.lane[l].rem = t[47:0];
         end
      end
      return o;
   endfunction

   function automatic logic [23:0] gd_final(gd_lane_type g);
      logic [23:0] r;
      if (g.a2z)
         r = '0;
      else if (g.ovf || (g.quo > D_MAX))
         r = D_MAX;
      else
         r = g.quo;
      return r;
   endfunction

endpackage

// ===== rtl/core/dual_lobe_ggx_specular.sv =====
// Dual-lobe GGX specular evaluator, fully pipelined.
// Depends on dlgs_pkg for constants, stage types and step functions.
//
// Usage:
//   req_* carries one shading sample per beat: N, V and L in signed Q1.14.
//   rsp_* returns one RGB specular beat per sample, unsigned Q4.12,
//   saturated, in the order the samples came in.
//   csr_* writes the material registers (two roughnesses, lobe ratio,
//   three strengths); write only while no sample is in flight.
// Throughput: one sample per cycle, sustained while back-pressure does not hold the pipeline.
// Depth: dlgs_pkg::LATENCY register stages from the input beat to the output
//   register, set by the 25-step square root, the 31-step unit-dot divider
//   and the 24-step GGX divider, one step per stage.
// Reset: synchronous, clears all valid bits and loads the register defaults.
// Back-pressure: when rsp_tready is low with a result waiting, the whole
//   pipeline holds and req_tready drops; nothing is lost or repeated.
module dual_lobe_ggx_specular (
   input  logic         clock,
   input  logic         reset,
   // normal_x, normal_y, normal_z, view_x, view_y, view_z,
   // light_x, light_y, light_z (16 bits each, lowest first)
   input  logic [143:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // spec_red, spec_green, spec_blue (16 bits each, lowest first)
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int LAT = dlgs_pkg::LATENCY;

   logic en;
   logic [LAT-1:0] vld_ff, vld_in;

   // config registers
   logic [15:0] rough_ff [2];
   logic [15:0] ratio_ff;
   logic [15:0] str_ff [3];

   // global advance: the whole pipe moves unless the output is stuck
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign vld_in     = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // register write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         rough_ff[0] <= dlgs_pkg::RST_ROUGH_PRI;
         rough_ff[1] <= dlgs_pkg::RST_ROUGH_SEC;
         ratio_ff    <= dlgs_pkg::RST_RATIO;
         str_ff[0]   <= dlgs_pkg::RST_STRENGTH;
         str_ff[1]   <= dlgs_pkg::RST_STRENGTH;
         str_ff[2]   <= dlgs_pkg::RST_STRENGTH;
      end else if (csr_wen) begin
         unique case (csr_addr)
            dlgs_pkg::CSR_ROUGH_PRI: rough_ff[0] <= csr_wdata;
            dlgs_pkg::CSR_ROUGH_SEC: rough_ff[1] <= csr_wdata;
            dlgs_pkg::CSR_RATIO:     ratio_ff    <= csr_wdata;
            dlgs_pkg::CSR_STR_RED:   str_ff[0]   <= csr_wdata;
            dlgs_pkg::CSR_STR_GREEN: str_ff[1]   <= csr_wdata;
            dlgs_pkg::CSR_STR_BLUE:  str_ff[2]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- stage 1: unpack, S = V + L
   logic signed [15:0] n_ff [3], n_in [3];
   logic signed [15:0] v_ff [3], v_in [3];
   logic signed [17:0] s_ff [3], s_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = req_tdata[16*i +: 16];
         v_in[i] = req_tdata[16*(3+i) +: 16];
         s_in[i] = {{2{req_tdata[16*(3+i)+15]}}, req_tdata[16*(3+i) +: 16]}
                 + {{2{req_tdata[16*(6+i)+15]}}, req_tdata[16*(6+i) +: 16]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         v_ff <= v_in;
         s_ff <= s_in;
      end
   end

   // ---- stage 2: |S|^2, N.S, S.V; seeds the square root
   dlgs_pkg::sq_type sq_ff [dlgs_pkg::SQ_STEPS+1];
   dlgs_pkg::sq_type sq0_in;

   always_comb begin
      logic signed [35:0] ss_sum;
      logic signed [35:0] ns_sum;
      logic signed [35:0] sv_sum;
      ss_sum = s_ff[0]*s_ff[0] + s_ff[1]*s_ff[1] + s_ff[2]*s_ff[2];
      ns_sum = n_ff[0]*s_ff[0] + n_ff[1]*s_ff[1] + n_ff[2]*s_ff[2];
      sv_sum = s_ff[0]*v_ff[0] + s_ff[1]*v_ff[1] + s_ff[2]*v_ff[2];
      sq0_in.rad  = {1'b0, ss_sum[33:0], 16'd0};
      sq0_in.root = '0;
      sq0_in.ns   = ns_sum;
      sq0_in.sv   = sv_sum;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq0_in;
      end
   end

   // ---- square root, one digit per stage
   for (genvar i = 0; i < dlgs_pkg::SQ_STEPS; i++) begin : g_sq
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i+1] <= dlgs_pkg::sq_step(sq_ff[i], 5'(dlgs_pkg::SQ_STEPS - 1 - i));
         end
      end
   end

   // ---- unit-dot divider setup: N.H and H.V share |S|
   dlgs_pkg::ud_type ud_ff [dlgs_pkg::UD_STEPS+1];
   dlgs_pkg::ud_type ud0_in;

   always_comb begin
      ud0_in.len     = sq_ff[dlgs_pkg::SQ_STEPS].root[24:0];
      ud0_in.lane[0] = dlgs_pkg::ud_init(sq_ff[dlgs_pkg::SQ_STEPS].ns, ud0_in.len);
      ud0_in.lane[1] = dlgs_pkg::ud_init(sq_ff[dlgs_pkg::SQ_STEPS].sv, ud0_in.len);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ud_ff[0] <= ud0_in;
      end
   end

   for (genvar i = 0; i < dlgs_pkg::UD_STEPS; i++) begin : g_ud
      always_ff @(posedge clock) begin
         if (en) begin
            ud_ff[i+1] <= dlgs_pkg::ud_step(ud_ff[i], 5'(dlgs_pkg::UD_STEPS - 1 - i));
         end
      end
   end

   // ---- E0: clamped N.H and H.V
   logic [30:0] nh_ff, hv_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nh_ff <= dlgs_pkg::ud_final(ud_ff[dlgs_pkg::UD_STEPS].lane[0]);
         hv_ff <= dlgs_pkg::ud_final(ud_ff[dlgs_pkg::UD_STEPS].lane[1]);
      end
   end

   // ---- E1: a = r^2, NdotH^2, t = 1 - HdotV
   logic [29:0] a_ff [2], a_in [2];
   logic [30:0] nh2_e1_ff, nh2_in, t_e1_ff, t_in;

   always_comb begin
      logic [31:0] rr;
      logic [61:0] pp;
      for (int l = 0; l < 2; l++) begin
         rr      = rough_ff[l] * rough_ff[l];
         a_in[l] = rr[31:2];
      end
      pp     = 62'(nh_ff) * 62'(nh_ff);
      nh2_in = pp[60:30];
      t_in   = dlgs_pkg::ONE_Q30 - hv_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= a_in;
         nh2_e1_ff <= nh2_in;
         t_e1_ff   <= t_in;
      end
   end

   // ---- E2: a^2, t^2
   logic [29:0] a2_e2_ff [2], a2_in [2];
   logic [30:0] nh2_e2_ff, t_e2_ff, p2_ff, p2_in;

   always_comb begin
      logic [59:0] aa;
      logic [61:0] pp;
      for (int l = 0; l < 2; l++) begin
         aa       = 60'(a_ff[l]) * 60'(a_ff[l]);
         a2_in[l] = aa[59:30];
      end
      pp    = 62'(t_e1_ff) * 62'(t_e1_ff);
      p2_in = pp[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_e2_ff  <= a2_in;
         nh2_e2_ff <= nh2_e1_ff;
         t_e2_ff   <= t_e1_ff;
         p2_ff     <= p2_in;
      end
   end

   // ---- E3: GGX denominator 1 - NdotH^2 * (1 - a^2), t^3
   logic [29:0] a2_e3_ff [2];
   logic [30:0] den_ff [2], den_in [2];
   logic [30:0] t_e3_ff, p3_ff, p3_in;

   always_comb begin
      logic [61:0] pp;
      logic [61:0] qq;
      for (int l = 0; l < 2; l++) begin
         pp        = 62'(nh2_e2_ff) * 62'(dlgs_pkg::ONE_Q30 - {1'b0, a2_e2_ff[l]});
         den_in[l] = dlgs_pkg::ONE_Q30 - pp[60:30];
      end
      qq    = 62'(p2_ff) * 62'(t_e2_ff);
      p3_in = qq[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_e3_ff <= a2_e2_ff;
         den_ff   <= den_in;
         t_e3_ff  <= t_e2_ff;
         p3_ff    <= p3_in;
      end
   end

   // ---- E4: den^2, t^4
   logic [29:0] a2_e4_ff [2];
   logic [46:0] dd_ff [2], dd_in [2];
   logic [30:0] t_e4_ff, p4_ff, p4_in;

   always_comb begin
      logic [61:0] pp;
      logic [61:0] qq;
      for (int l = 0; l < 2; l++) begin
         pp       = 62'(den_ff[l]) * 62'(den_ff[l]);
         dd_in[l] = pp[60:14];
      end
      qq    = 62'(p3_ff) * 62'(t_e3_ff);
      p4_in = qq[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_e4_ff <= a2_e3_ff;
         dd_ff    <= dd_in;
         t_e4_ff  <= t_e3_ff;
         p4_ff    <= p4_in;
      end
   end

   // ---- E5: pi * dd in two partial products, t^5
   logic [29:0] a2_e5_ff [2];
   logic [41:0] pl_ff [2], pl_in [2];
   logic [40:0] ph_ff [2], ph_in [2];
   logic [30:0] p5_ff, p5_in;

   always_comb begin
      logic [61:0] qq;
      for (int l = 0; l < 2; l++) begin
         pl_in[l] = 42'(dd_ff[l][23:0]) * 42'(dlgs_pkg::PI_Q16);
         ph_in[l] = 41'(dd_ff[l][46:24]) * 41'(dlgs_pkg::PI_Q16);
      end
      qq    = 62'(p4_ff) * 62'(t_e4_ff);
      p5_in = qq[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_e5_ff <= a2_e4_ff;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         p5_ff    <= p5_in;
      end
   end

   // ---- E6: join partial products, Schlick Fresnel
   logic [29:0] a2_e6_ff [2];
   logic [47:0] pd_ff [2], pd_in [2];
   logic [30:0] f_e6_ff, f_in;

   always_comb begin
      logic [64:0] full;
      logic [61:0] qq;
      for (int l = 0; l < 2; l++) begin
         full     = {ph_ff[l], 24'd0} + 65'(pl_ff[l]);
         pd_in[l] = full[63:16];
      end
      qq   = 62'(dlgs_pkg::OMF_Q30) * 62'(p5_ff);
      f_in = dlgs_pkg::F0_Q30 + qq[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_e6_ff <= a2_e5_ff;
         pd_ff    <= pd_in;
         f_e6_ff  <= f_in;
      end
   end

   // ---- GGX divider: a^2 * 2^32 / pd for both lobes
   dlgs_pkg::gd_type gd_ff [dlgs_pkg::GD_STEPS+1];
   dlgs_pkg::gd_type gd0_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         gd0_in.lane[l] = dlgs_pkg::gd_init(a2_e6_ff[l], pd_ff[l]);
      end
      gd0_in.f = f_e6_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gd_ff[0] <= gd0_in;
      end
   end

   for (genvar i = 0; i < dlgs_pkg::GD_STEPS; i++) begin : g_gd
      always_ff @(posedge clock) begin
         if (en) begin
            gd_ff[i+1] <= dlgs_pkg::gd_step(gd_ff[i], 5'(dlgs_pkg::GD_STEPS - 1 - i));
         end
      end
   end

   // ---- saturated D per lobe
   logic [23:0] d_ff [2];
   logic [30:0] f_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= dlgs_pkg::gd_final(gd_ff[dlgs_pkg::GD_STEPS].lane[0]);
         d_ff[1] <= dlgs_pkg::gd_final(gd_ff[dlgs_pkg::GD_STEPS].lane[1]);
         f_d_ff  <= gd_ff[dlgs_pkg::GD_STEPS].f;
      end
   end

   // ---- M1: lobe weights
   logic [39:0] m1_ff;
   logic [40:0] m2_ff;
   logic [30:0] f_m1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= 40'(d_ff[0]) * 40'(ratio_ff);
         m2_ff   <= 41'(d_ff[1]) * 41'(17'h1_0000 - {1'b0, ratio_ff});
         f_m1_ff <= f_d_ff;
      end
   end

   // ---- M2: mixed D
   logic [23:0] dm_ff;
   logic [30:0] f_m2_ff;
   logic [41:0] msum;

   assign msum = 42'(m1_ff) + 42'(m2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dm_ff   <= msum[39:16];
         f_m2_ff <= f_m1_ff;
      end
   end

   // ---- M3: D * F (visibility folded into the final shift)
   logic [23:0] df_ff;
   logic [54:0] dfp;

   assign dfp = 55'(dm_ff) * 55'(f_m2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         df_ff <= dfp[53:30];
      end
   end

   // ---- output register: per-channel strength, saturate
   logic [15:0] spec_ff [3], spec_in [3];

   always_comb begin
      logic [39:0] cp;
      for (int c = 0; c < 3; c++) begin
         cp         = 40'(df_ff) * 40'(str_ff[c]);
         spec_in[c] = (cp[39:38] != 2'b00) ? 16'hFFFF : cp[37:22];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff <= spec_in;
      end
   end

   assign rsp_tdata = {spec_ff[2], spec_ff[1], spec_ff[0]};

endmodule
